@@ hw/rtl/trsq_pkg.sv @@
// ----------------------------------------------------------------------------
// trsq_pkg
// Shared types and constants of the token ring station queues block.
// ----------------------------------------------------------------------------
package trsq_pkg;

  localparam int unsigned MAX_STATIONS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF  = 16;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SEL_W    = 8;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned HOLDER_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  typedef enum logic {
    FUNC_STEP = 1'b0,
    FUNC_ENQ  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    STATUS_IDLE    = 3'd0,
    STATUS_SENT    = 3'd1,
    STATUS_QUEUED  = 3'd2,
    STATUS_FULL    = 3'd3,
    STATUS_INVALID = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PTR,
    S_DATA
  } state_e;

endpackage

@@ hw/rtl/trsq_ptr_mem.sv @@
// ----------------------------------------------------------------------------
// trsq_ptr_mem
// Per-station head pointer and fill count store, registered synchronous read.
// A valid bit per station makes unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module trsq_ptr_mem #(
  parameter int unsigned DEPTH  = trsq_pkg::MAX_STATIONS_DEF,
  parameter int unsigned HEAD_W = 4,
  parameter int unsigned FILL_W = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [HEAD_W-1:0]        rd_head_o,
  output logic [FILL_W-1:0]        rd_fill_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [HEAD_W-1:0]        wr_head_i,
  input  logic [FILL_W-1:0]        wr_fill_i
);

  localparam int unsigned ENTRY_W = HEAD_W + FILL_W;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic [ENTRY_W-1:0] rd_raw_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_head_i, wr_fill_i};
    end
    if (rd_en_i) begin
      rd_raw_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_head_o = rd_vld_q ? rd_raw_q[ENTRY_W-1:FILL_W] : '0;
  assign rd_fill_o = rd_vld_q ? rd_raw_q[FILL_W-1:0] : '0;

endmodule

@@ hw/rtl/trsq_data_mem.sv @@
// ----------------------------------------------------------------------------
// trsq_data_mem
// Queue word store shared by all stations, one write and one registered read
// port.
// ----------------------------------------------------------------------------
module trsq_data_mem #(
  parameter int unsigned DEPTH = trsq_pkg::MAX_STATIONS_DEF * trsq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WIDTH = trsq_pkg::WORD_W
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/token_ring_station_queues_core.sv @@
// ----------------------------------------------------------------------------
// token_ring_station_queues_core
// Token ring of up to MAX_STATIONS stations, each with a FIFO of QUEUE_DEPTH
// 32-bit words, driven by step and enqueue transactions.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. The pointer memory is read at the
// accepting edge. In the pointer stage the pointers are updated and written
// back, and an enqueue or a step whose holder has nothing to send loads its
// result into the output register at the same edge, once the output is free.
// A step that sends a word reads the queue memory at that edge and loads its
// result from the data stage. Input ready is high only while idle, so a new
// transaction is taken only once the last has loaded its result. A result
// waiting at the output does not block acceptance, but the next one then holds
// in its pointer stage (a sending step in its data stage) until it is taken.
// Pointer state starts empty right out of reset (valid bits per station), so
// no clearing pass is needed. The station count register may be written
// at any time the block is idle; queued words are kept across changes.
// ----------------------------------------------------------------------------
module token_ring_station_queues_core #(
  parameter int unsigned MAX_STATIONS = trsq_pkg::MAX_STATIONS_DEF,
  parameter int unsigned QUEUE_DEPTH  = trsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: station_count
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [7:0] station_sel, [39:8] data_word
  input  logic        s_axis_tuser_i,   // [0] func
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] station_num, [10:8] next_holder,
                                        // [42:11] sent_word, [47:43] zero
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  localparam int unsigned SW  = $clog2(MAX_STATIONS);
  localparam int unsigned PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW  = $clog2(MAX_STATIONS * QUEUE_DEPTH);
  localparam int unsigned WW  = trsq_pkg::WORD_W;
  localparam int unsigned SLW = trsq_pkg::SEL_W;
  localparam int unsigned HLW = trsq_pkg::HOLDER_W;

  localparam logic [SLW-1:0] MAX_ST8    = SLW'(MAX_STATIONS);
  localparam logic [PW-1:0]  HEAD_LAST  = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0]  FILL_FULL  = FW'(QUEUE_DEPTH);
  localparam logic [FW:0]    SLOT_WRAP  = (FW + 1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0]  ROW_STRIDE = AW'(QUEUE_DEPTH);

  // registers
  trsq_pkg::state_e           state_q, state_d;
  logic [trsq_pkg::COUNT_W-1:0] count_q;
  logic [SW-1:0]              holder_q, holder_d;
  trsq_pkg::func_e            func_q;
  logic [SLW-1:0]             sel_q;
  logic [WW-1:0]              word_q;
  logic [SW-1:0]              target_q;
  logic [SLW-1:0]             pend_num_q;
  logic [HLW-1:0]             pend_nh_q;
  logic                       m_valid_q;
  logic [47:0]                m_data_q;
  trsq_pkg::status_e          m_status_q;

  // memory ports
  logic          ptr_re, ptr_we, dmem_re, dmem_we;
  logic [SW-1:0] ptr_raddr;
  logic [PW-1:0] ptr_head, new_head;
  logic [FW-1:0] ptr_fill, new_fill;
  logic [AW-1:0] dmem_raddr, dmem_waddr;
  logic [WW-1:0] dmem_rdata;

  // decode
  logic              s_accept, out_free, has_word, sel_ok, q_full, send;
  logic              commit, out_load_ptr, out_load_data, holder_upd;
  logic [SLW-1:0]    cnt8, hold8, hold_inc8;
  logic [SW-1:0]     holder_wrap;
  logic [SW+HLW-1:0] hold_ext;
  logic [FW:0]       slot_sum, slot_fix;
  logic [PW-1:0]     slot;
  trsq_pkg::status_e res_status;
  logic [SLW-1:0]    res_num;
  logic [HLW-1:0]    res_nh;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= trsq_pkg::COUNT_RESET;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // effective station count: zero means one, saturate at MAX_STATIONS
  always_comb begin
    cnt8 = SLW'(count_q);
    if (count_q == '0) begin
      cnt8 = SLW'(1);
    end else if (cnt8 > MAX_ST8) begin
      cnt8 = MAX_ST8;
    end
  end

  assign hold8       = SLW'(holder_q);
  assign hold_inc8   = hold8 + SLW'(1);
  assign holder_wrap = (hold_inc8 >= cnt8) ? '0 : SW'(hold_inc8);

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign has_word = (ptr_fill != '0);
  assign sel_ok   = (sel_q < cnt8);
  assign q_full   = (ptr_fill == FILL_FULL);
  assign send     = (func_q == trsq_pkg::FUNC_STEP) && has_word;

  // tail slot = (head + fill) mod depth, sum stays below twice the depth
  assign slot_sum = (FW + 1)'(ptr_head) + (FW + 1)'(ptr_fill);
  assign slot_fix = (slot_sum >= SLOT_WRAP) ? (slot_sum - SLOT_WRAP) : slot_sum;
  assign slot     = PW'(slot_fix);

  always_comb begin
    new_head = ptr_head;
    new_fill = ptr_fill;
    if (func_q == trsq_pkg::FUNC_STEP) begin
      new_head = (ptr_head == HEAD_LAST) ? '0 : ptr_head + PW'(1);
      new_fill = ptr_fill - FW'(1);
    end else begin
      new_fill = ptr_fill + FW'(1);
    end
  end

  always_comb begin
    res_num    = sel_q;
    res_status = trsq_pkg::STATUS_QUEUED;
    if (func_q == trsq_pkg::FUNC_STEP) begin
      res_num    = hold8;
      res_status = has_word ? trsq_pkg::STATUS_SENT : trsq_pkg::STATUS_IDLE;
    end else if (!sel_ok) begin
      res_status = trsq_pkg::STATUS_INVALID;
    end else if (q_full) begin
      res_status = trsq_pkg::STATUS_FULL;
    end
  end

  assign holder_d = (func_q == trsq_pkg::FUNC_STEP) ? holder_wrap : holder_q;
  assign hold_ext = (SW + HLW)'(holder_d);
  assign res_nh   = hold_ext[HLW-1:0];

  assign dmem_raddr = AW'(target_q) * ROW_STRIDE + AW'(ptr_head);
  assign dmem_waddr = AW'(target_q) * ROW_STRIDE + AW'(slot);
  assign ptr_raddr  = (s_axis_tuser_i == trsq_pkg::FUNC_STEP) ? holder_q
                                                              : SW'(s_axis_tdata_i[7:0]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      trsq_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = trsq_pkg::S_PTR;
        end
      end
      trsq_pkg::S_PTR: begin
        if (send) begin
          state_d = trsq_pkg::S_DATA;
        end else if (out_free) begin
          state_d = trsq_pkg::S_IDLE;
        end
      end
      trsq_pkg::S_DATA: begin
        if (out_free) begin
          state_d = trsq_pkg::S_IDLE;
        end
      end
      default: state_d = trsq_pkg::S_IDLE;
    endcase
  end

  // controls
  always_comb begin
    s_axis_tready_o = 1'b0;
    ptr_re          = 1'b0;
    commit          = 1'b0;
    out_load_ptr    = 1'b0;
    out_load_data   = 1'b0;
    case (state_q)
      trsq_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        ptr_re          = s_axis_tvalid_i;
      end
      trsq_pkg::S_PTR: begin
        commit       = send || out_free;
        out_load_ptr = !send && out_free;
      end
      trsq_pkg::S_DATA: begin
        out_load_data = out_free;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  assign holder_upd = commit && (func_q == trsq_pkg::FUNC_STEP);
  assign dmem_re    = commit && send;
  assign dmem_we    = commit && (func_q == trsq_pkg::FUNC_ENQ) && sel_ok && !q_full;
  assign ptr_we     = dmem_re || dmem_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= trsq_pkg::S_IDLE;
      holder_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (holder_upd) begin
        holder_q <= holder_d;
      end
      if (out_load_ptr || out_load_data) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      func_q   <= trsq_pkg::func_e'(s_axis_tuser_i);
      sel_q    <= s_axis_tdata_i[7:0];
      word_q   <= s_axis_tdata_i[39:8];
      target_q <= ptr_raddr;
    end
    if (dmem_re) begin
      pend_num_q <= res_num;
      pend_nh_q  <= res_nh;
    end
    if (out_load_ptr) begin
      m_status_q <= res_status;
      m_data_q   <= {5'b0, WW'(0), res_nh, res_num};
    end else if (out_load_data) begin
      m_status_q <= trsq_pkg::STATUS_SENT;
      m_data_q   <= {5'b0, dmem_rdata, pend_nh_q, pend_num_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_status_q;

  trsq_ptr_mem #(
    .DEPTH  (MAX_STATIONS),
    .HEAD_W (PW),
    .FILL_W (FW)
  ) u_ptr_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ptr_re),
    .rd_addr_i (ptr_raddr),
    .rd_head_o (ptr_head),
    .rd_fill_o (ptr_fill),
    .wr_en_i   (ptr_we),
    .wr_addr_i (target_q),
    .wr_head_i (new_head),
    .wr_fill_i (new_fill)
  );

  trsq_data_mem #(
    .DEPTH (MAX_STATIONS * QUEUE_DEPTH),
    .WIDTH (WW)
  ) u_data_mem (
    .clk_i     (clk_i),
    .rd_en_i   (dmem_re),
    .rd_addr_i (dmem_raddr),
    .rd_data_o (dmem_rdata),
    .wr_en_i   (dmem_we),
    .wr_addr_i (dmem_waddr),
    .wr_data_i (word_q)
  );

  // assertions
  a_accept_to_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == trsq_pkg::S_PTR))
    else $error("accepted transaction did not move to pointer stage");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dmem_re |-> (ptr_fill != '0) && (state_q == trsq_pkg::S_PTR))
    else $error("queue read from an empty station");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_we |-> (new_fill <= FILL_FULL))
    else $error("fill count beyond queue depth");

  a_enq_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dmem_we |-> (func_q == trsq_pkg::FUNC_ENQ) && (sel_q < cnt8))
    else $error("queue write for an invalid station");

  a_holder_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    holder_upd |=> (SLW'(holder_q) < cnt8) || (holder_q == '0))
    else $error("token passed beyond station count");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the token ring station queues core. A clocked
// driver offers step and enqueue transactions from a pending queue, predicts
// each result on acceptance from its own copy of the ring and FIFO state,
// and a clocked monitor compares every result field by field. The run walks
// through several station counts, with random gaps, stalls and one long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NST         = trsq_pkg::MAX_STATIONS_DEF;
  localparam int unsigned QD          = trsq_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned WW          = trsq_pkg::WORD_W;
  localparam int unsigned CW          = trsq_pkg::COUNT_W;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned HOLD_AFTER  = 1000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned NUM_PHASES  = 12;
  localparam logic [CW-1:0] COUNT_PLAN [NUM_PHASES] = '{
    4'd15, 4'd2, 4'd8, 4'd1, 4'd5, 4'd3, 4'd7, 4'd0, 4'd12, 4'd4, 4'd6, 4'd8
  };

  typedef struct {
    trsq_pkg::func_e                func;
    logic [trsq_pkg::SEL_W-1:0]     sel;
    logic [WW-1:0]                  word;
  } ring_item_t;

  typedef struct {
    trsq_pkg::status_e              status;
    logic [trsq_pkg::SEL_W-1:0]     station;
    logic [trsq_pkg::HOLDER_W-1:0]  next_holder;
    logic [WW-1:0]                  sent;
  } ring_result_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_valid_i     = 1'b0;
  logic               cfg_ready_o;
  logic [CW-1:0]      cfg_data_i      = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [39:0]        s_axis_tdata_i  = '0;  // [7:0] station_sel, [39:8] data_word
  logic               s_axis_tuser_i  = 1'b0; // [0] func
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [47:0]        m_axis_tdata_o;         // [7:0] station_num, [10:8] next_holder,
                                              // [42:11] sent_word, [47:43] zero
  logic [2:0]         m_axis_tuser_o;         // [2:0] status

  token_ring_station_queues_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // ring and FIFO state as the block should hold it
  logic [WW-1:0]      ring_words [NST][QD];
  int unsigned        ring_head [NST];
  int unsigned        ring_fill [NST];
  int unsigned        ring_holder;
  logic [CW-1:0]      ring_count;

  ring_item_t   pending_items[$];
  ring_result_t expected_results[$];
  ring_item_t   on_offer;
  ring_result_t want_result;

  bit          quiet;
  bit          long_hold_done;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned configs_written;
  int unsigned status_tally [5];
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned cycle_count;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned ring_span(logic [CW-1:0] c);
    if (c == 0) return 1;
    if (c > NST) return NST;
    return 32'(c);
  endfunction

  // applies one transaction to the ring state and returns its result
  function automatic ring_result_t ring_apply(ring_item_t it);
    ring_result_t r;
    int unsigned span;
    int unsigned h;
    int unsigned slot;
    span = ring_span(ring_count);
    r.sent = '0;
    if (it.func == trsq_pkg::FUNC_STEP) begin
      h = ring_holder;
      r.station = h[trsq_pkg::SEL_W-1:0];
      if (ring_fill[h] != 0) begin
        r.sent = ring_words[h][ring_head[h]];
        ring_head[h] = (ring_head[h] + 1) % QD;
        ring_fill[h]--;
        r.status = trsq_pkg::STATUS_SENT;
      end else begin
        r.status = trsq_pkg::STATUS_IDLE;
      end
      // a holder left beyond a reduced count wraps to station 0
      ring_holder = (h + 1 >= span) ? 0 : h + 1;
    end else begin
      r.station = it.sel;
      if (it.sel >= span) begin
        r.status = trsq_pkg::STATUS_INVALID;
      end else if (ring_fill[it.sel] >= QD) begin
        r.status = trsq_pkg::STATUS_FULL;
      end else begin
        slot = (ring_head[it.sel] + ring_fill[it.sel]) % QD;
        ring_words[it.sel][slot] = it.word;
        ring_fill[it.sel]++;
        r.status = trsq_pkg::STATUS_QUEUED;
      end
    end
    r.next_holder = ring_holder[trsq_pkg::HOLDER_W-1:0];
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_item(trsq_pkg::func_e f, int unsigned sel,
                                    logic [WW-1:0] w);
    ring_item_t it;
    it.func = f;
    it.sel  = sel[trsq_pkg::SEL_W-1:0];
    it.word = w;
    pending_items.push_back(it);
  endfunction

  task automatic report_mismatch(string field, logic [WW-1:0] got,
                                 logic [WW-1:0] want);
    $display("result %0d: %s is %0h, expected %0h", results_checked, field, got, want);
    mismatches++;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_items.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_station_count(logic [CW-1:0] value);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ring_count = value;
    configs_written++;
  endtask

  // mostly enqueue bursts to live stations and runs of steps, some noise
  task automatic queue_random_phase(int unsigned n);
    int unsigned span;
    int unsigned made;
    int unsigned kind;
    int unsigned len;
    int unsigned st;
    span = ring_span(ring_count);
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        st  = $urandom_range(0, span - 1);
        len = $urandom_range(1, 20);
        repeat (len) push_item(trsq_pkg::FUNC_ENQ, st, $urandom());
      end else if (kind < 80) begin
        len = $urandom_range(1, 3 * span + 2);
        repeat (len) push_item(trsq_pkg::FUNC_STEP, $urandom_range(0, 255), $urandom());
      end else if (kind < 92) begin
        len = 1;
        push_item(trsq_pkg::func_e'($urandom_range(0, 1)), $urandom_range(0, NST),
                  $urandom());
      end else begin
        len = 1;
        push_item(trsq_pkg::func_e'($urandom_range(0, 1)), $urandom_range(0, 255),
                  $urandom());
      end
      made += len;
    end
  endtask

  // driver: predicts on each accepted transaction, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_results.push_back(ring_apply(on_offer));
        items_accepted++;
        send_gap = quiet ? 0 : draw_gap();
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          on_offer = pending_items.pop_front();
          s_axis_tdata_i  <= {on_offer.word, on_offer.sel};
          s_axis_tuser_i  <= on_offer.func;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives ready with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction, tdata", m_axis_tdata_o[31:0], '0);
        end else begin
          want_result = expected_results.pop_front();
          status_tally[int'(want_result.status)]++;
          if (m_axis_tuser_o !== want_result.status)
            report_mismatch("status", WW'(m_axis_tuser_o), WW'(want_result.status));
          if (m_axis_tdata_o[7:0] !== want_result.station)
            report_mismatch("station_num", WW'(m_axis_tdata_o[7:0]),
                            WW'(want_result.station));
          if (m_axis_tdata_o[10:8] !== want_result.next_holder)
            report_mismatch("next_holder", WW'(m_axis_tdata_o[10:8]),
                            WW'(want_result.next_holder));
          if (m_axis_tdata_o[42:11] !== want_result.sent)
            report_mismatch("sent_word", m_axis_tdata_o[42:11], want_result.sent);
          if (m_axis_tdata_o[47:43] !== 5'd0)
            report_mismatch("tdata padding", WW'(m_axis_tdata_o[47:43]), '0);
        end
        results_checked++;
      end
      // one long hold-off while the sender still has plenty queued
      if (stall_left == 0 && !long_hold_done && items_accepted >= HOLD_AFTER &&
          pending_items.size() >= 20) begin
        stall_left = HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = draw_gap();
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NST; s++) begin
      ring_head[s] = 0;
      ring_fill[s] = 0;
    end
    for (int k = 0; k < 5; k++) status_tally[k] = 0;
    ring_holder = 0;
    ring_count  = trsq_pkg::COUNT_RESET;
    quiet       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset count of 8: word extremes, bad stations, token walk up to station 6
    push_item(trsq_pkg::FUNC_ENQ, 7, 32'hFFFF_FFFF);
    push_item(trsq_pkg::FUNC_ENQ, 6, 32'h8000_0000);
    push_item(trsq_pkg::FUNC_ENQ, 6, 32'h7FFF_FFFF);
    push_item(trsq_pkg::FUNC_ENQ, 8, 32'h0000_0000);
    push_item(trsq_pkg::FUNC_ENQ, 255, 32'h5555_5555);
    push_item(trsq_pkg::FUNC_STEP, 255, 32'hAAAA_AAAA);
    repeat (5) push_item(trsq_pkg::FUNC_STEP, 0, 32'h0);

    // shrink the ring under the holder: it still sends, then wraps to 0
    set_station_count(4'd3);
    push_item(trsq_pkg::FUNC_STEP, 0, 32'h0);
    push_item(trsq_pkg::FUNC_ENQ, 6, 32'h0000_0001);
    push_item(trsq_pkg::FUNC_STEP, 0, 32'h0);

    // zero count acts as one station; fill station 0 until refused
    set_station_count(4'd0);
    push_item(trsq_pkg::FUNC_ENQ, 1, 32'h1234_5678);
    for (int k = 0; k < QD; k++)
      push_item(trsq_pkg::FUNC_ENQ, 0,
                (k % 2 == 0) ? ~(32'h1 << k) : (32'h1 << (31 - k)));
    push_item(trsq_pkg::FUNC_ENQ, 0, 32'hDEAD_BEEF);
    push_item(trsq_pkg::FUNC_STEP, 0, 32'h0);
    push_item(trsq_pkg::FUNC_STEP, 0, 32'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet = ($urandom_range(0, 3) == 0);
      set_station_count(COUNT_PLAN[p]);
      queue_random_phase(PHASE_ITEMS);
    end

    wait_idle();
    repeat (12) @(posedge clk_i);
    $display("%0d transactions checked across %0d station-count settings (0, 1, 8, 15 included)",
             results_checked, configs_written);
    $display("idle passes %0d, sends %0d, queued %0d, full %0d, invalid %0d",
             status_tally[int'(trsq_pkg::STATUS_IDLE)],
             status_tally[int'(trsq_pkg::STATUS_SENT)],
             status_tally[int'(trsq_pkg::STATUS_QUEUED)],
             status_tally[int'(trsq_pkg::STATUS_FULL)],
             status_tally[int'(trsq_pkg::STATUS_INVALID)]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ token_ring_station_queues_core.f @@
hw/rtl/trsq_pkg.sv
hw/rtl/trsq_ptr_mem.sv
hw/rtl/trsq_data_mem.sv
hw/rtl/token_ring_station_queues_core.sv
dv/tb_top.sv
